// ===== rtl/letter_frequency_ranker_core_assert.svh =====
// Assertion macros used by the letter frequency ranker sequencer.
`ifndef LETTER_FREQUENCY_RANKER_CORE_ASSERT_SVH
`define LETTER_FREQUENCY_RANKER_CORE_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define LFR_ASSERT_HOLDS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true at a clock edge outside reset.
`define LFR_ASSERT_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/lfr_pkg.sv =====
// Shared types, constants and helpers for the letter frequency ranker.
package lfr_pkg;

	localparam int NumLetters = 26;
	localparam int MaxChars   = 1024;
	localparam int CountW     = 11;
	localparam int LetterW    = 5;
	localparam int PhaseW     = 5;

	localparam int CountFieldMax = (1 << CountW) - 1;
	localparam logic [CountW-1:0] CountCap =
		CountW'((MaxChars > CountFieldMax) ? CountFieldMax : MaxChars);

	localparam logic [7:0] LetterFirst = 8'h61;
	localparam logic [7:0] LetterLast  = 8'h7A;
	localparam logic [LetterW-1:0] LastIndex = LetterW'(NumLetters - 1);
	localparam logic [PhaseW-1:0] LastPhase  = PhaseW'(NumLetters - 1);

	// Operation broadcast to every cell of the chain.
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_COUNT,
		CELL_SORT,
		CELL_SHIFT,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic               odd_phase;
		logic               letter_ok;
		logic [LetterW-1:0] letter_sel;
	} cell_ctrl_t;

	// One entry of the chain: which letter and how often it was seen.
	typedef struct packed {
		logic [LetterW-1:0] letter;
		logic [CountW-1:0]  count;
	} cell_t;

	// True when entry a ranks ahead of entry b: higher count, then lower letter.
	function automatic logic ranks_ahead(cell_t a, cell_t b);
		ranks_ahead = (a.count > b.count) ||
			((a.count == b.count) && (a.letter < b.letter));
	endfunction

endpackage

// ===== rtl/lfr_cell.sv =====
// One cell of the chain: a letter counter that also sorts and shifts with its neighbors.
module lfr_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [lfr_pkg::LetterW-1:0]  index,
	input  lfr_pkg::cell_ctrl_t          ctrl,
	input  lfr_pkg::cell_t               left_in,
	input  lfr_pkg::cell_t               right_in,
	output lfr_pkg::cell_t               data
);
	import lfr_pkg::*;

	cell_t data_q;
	cell_t sort_next;
	logic  has_left;
	logic  has_right;
	logic  pair_right;

	assign has_left   = (index != '0);
	assign has_right  = (index != LastIndex);
	assign pair_right = (index[0] == ctrl.odd_phase);

	// Odd-even transposition: the lower position of a pair keeps the better entry.
	always_comb begin
		sort_next = data_q;
		if (pair_right) begin
			if (has_right && ranks_ahead(right_in, data_q)) begin
				sort_next = right_in;
			end
		end else begin
			if (has_left && ranks_ahead(data_q, left_in)) begin
				sort_next = left_in;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			unique case (ctrl.op)
				CELL_HOLD: begin
					data_q <= data_q;
				end
				CELL_COUNT: begin
					if (ctrl.letter_ok && (ctrl.letter_sel == data_q.letter) &&
						(data_q.count < CountCap)) begin
						data_q.count <= data_q.count + CountW'(1);
					end
				end
				CELL_SORT: begin
					data_q <= sort_next;
				end
				CELL_SHIFT: begin
					data_q <= right_in;
				end
				CELL_CLEAR: begin
					data_q.letter <= index;
					data_q.count  <= '0;
				end
				default: begin
					data_q <= data_q;
				end
			endcase
		end
	end

	assign data = data_q;

endmodule

// ===== rtl/lfr_ctrl.sv =====
// Sequencer for the ranker: counting, sorting and emitting phases and the stream handshakes.
module lfr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	input  logic [7:0]                  char_byte,
	input  logic                        end_of_text,
	input  logic                        m_tready,
	input  logic                        emit_last,
	output logic                        s_tready,
	output logic                        m_tvalid,
	output lfr_pkg::cell_ctrl_t         ctrl
);
	import lfr_pkg::*;

	`include "letter_frequency_ranker_core_assert.svh"

	typedef enum logic [1:0] {
		ST_INIT,
		ST_COUNT,
		ST_SORT,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [PhaseW-1:0] phase_q;
	logic              s_tready_q;
	logic              m_tvalid_q;
	logic              in_xfer;
	logic              out_xfer;
	logic [7:0]        letter_off;

	assign in_xfer    = s_tvalid && s_tready_q;
	assign out_xfer   = m_tvalid_q && m_tready;
	assign letter_off = char_byte - LetterFirst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			phase_q    <= '0;
			s_tready_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					state_q    <= ST_COUNT;
					s_tready_q <= 1'b1;
				end
				ST_COUNT: begin
					if (in_xfer && end_of_text) begin
						state_q    <= ST_SORT;
						phase_q    <= '0;
						s_tready_q <= 1'b0;
					end
				end
				ST_SORT: begin
					phase_q <= phase_q + PhaseW'(1);
					if (phase_q == LastPhase) begin
						state_q    <= ST_EMIT;
						m_tvalid_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_xfer && emit_last) begin
						state_q    <= ST_COUNT;
						m_tvalid_q <= 1'b0;
						s_tready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

	always_comb begin
		ctrl.odd_phase  = phase_q[0];
		ctrl.letter_ok  = (char_byte >= LetterFirst) && (char_byte <= LetterLast);
		ctrl.letter_sel = letter_off[LetterW-1:0];
		unique case (state_q)
			ST_INIT:  ctrl.op = CELL_CLEAR;
			ST_COUNT: ctrl.op = in_xfer ? CELL_COUNT : CELL_HOLD;
			ST_SORT:  ctrl.op = CELL_SORT;
			ST_EMIT: begin
				if (out_xfer) begin
					ctrl.op = emit_last ? CELL_CLEAR : CELL_SHIFT;
				end else begin
					ctrl.op = CELL_HOLD;
				end
			end
			default:  ctrl.op = CELL_HOLD;
		endcase
	end

	assign s_tready = s_tready_q;
	assign m_tvalid = m_tvalid_q;

	`LFR_ASSERT_NEVER(a_no_overlap, s_tready_q && m_tvalid_q, "input and output open together")
	`LFR_ASSERT_HOLDS(a_last_reopens, (out_xfer && emit_last) |=> s_tready_q, "input not reopened after last result")
	`LFR_ASSERT_HOLDS(a_sort_to_emit, (state_q == ST_SORT && phase_q == LastPhase) |=> m_tvalid_q, "results not offered after sort")
	`LFR_ASSERT_NEVER(a_phase_range, (state_q == ST_SORT) && (phase_q > LastPhase), "sort phase out of range")

endmodule

// ===== rtl/letter_frequency_ranker_core.sv =====
// Top level of the letter frequency ranker: a chain of counting and sorting cells.
// Bytes are taken one per cycle while s_tready is high; each is counted as it transfers.
// After the final byte the chain sorts itself by odd-even transposition.
// The first result is offered after sorting, then one per cycle while m_tready is high.
// After the last result transfers the counters clear and the next byte is taken next cycle.
// After reset the init state loads the cells' letters before the first byte is accepted.
module letter_frequency_ranker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] char_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] letter_code, [18:8] letter_count, rest zero
	output logic        m_tuser,   // [0] no_letters
	output logic        m_tlast    // last_result
);
	import lfr_pkg::*;

	cell_ctrl_t ctrl;
	cell_t      chain [NumLetters];
	cell_t      head;
	logic       head_empty;
	logic       emit_last;
	logic [7:0] letter_code;

	lfr_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.char_byte   (s_tdata),
		.end_of_text (s_tlast),
		.m_tready    (m_tready),
		.emit_last   (emit_last),
		.s_tready    (s_tready),
		.m_tvalid    (m_tvalid),
		.ctrl        (ctrl)
	);

	// Cell zero is the head of the chain; shifting moves entries toward it and
	// feeds an empty entry in at the far end.
	for (genvar i = 0; i < NumLetters; i++) begin : g_cell
		cell_t left_in;
		cell_t right_in;

		if (i == 0) begin : g_head
			assign left_in = '0;
		end else begin : g_mid
			assign left_in = chain[i-1];
		end

		if (i == NumLetters - 1) begin : g_tail
			assign right_in = '0;
		end else begin : g_body
			assign right_in = chain[i+1];
		end

		lfr_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.index    (LetterW'(i)),
			.ctrl     (ctrl),
			.left_in  (left_in),
			.right_in (right_in),
			.data     (chain[i])
		);
	end

	// After sorting, letters with a zero count sit behind all seen letters, so the
	// results end where the next entry has a zero count. An empty head means no
	// letter was seen at all, which yields the single empty result.
	assign head       = chain[0];
	assign head_empty = (head.count == '0);
	assign emit_last  = head_empty || (chain[1].count == '0);

	assign letter_code = head_empty ? 8'h00 : (LetterFirst + 8'(head.letter));

	assign m_tdata = {5'b0, head.count, letter_code};
	assign m_tuser = head_empty;
	assign m_tlast = emit_last;

endmodule
